FILE: src/voice_pool_allocator_with_fade_top_assert.svh
// ----------------------------------------------------------------------------
// Voice pool allocator assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef VOICE_POOL_ALLOCATOR_WITH_FADE_TOP_ASSERT_SVH
`define VOICE_POOL_ALLOCATOR_WITH_FADE_TOP_ASSERT_SVH

// same-cycle implication
`define VPA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vpa same-cycle check failed");

// next-cycle implication
`define VPA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vpa next-cycle check failed");

`endif

FILE: src/vpa_pkg.sv
// ----------------------------------------------------------------------------
// Voice pool allocator package
// Field widths, codes, fixed constants and controller/datapath link types.
// ----------------------------------------------------------------------------
package vpa_pkg;

  localparam int ACT_W  = 3;
  localparam int VN_W   = 6;
  localparam int GAIN_W = 13;
  localparam int TIME_W = 24;
  localparam int TICK_W = 16;
  localparam int KIND_W = 2;
  localparam int CNT_W  = 6;
  localparam int STEP_W = 4;
  localparam int PROD_W = GAIN_W + TIME_W;

  localparam logic [GAIN_W-1:0] Q_ONE    = 13'd4096;
  localparam logic [GAIN_W-1:0] HF_FLOOR = 13'd123;
  localparam logic [TIME_W-1:0] TIME_MAX = 24'hFFFFFF;
  localparam int                MAX_RESULTS = 32;
  localparam int                DIV_STEPS   = 13;

  // muffle * 0.92 rounded: (m*92+50)/100 through a reciprocal
  localparam logic [18:0] HF_MUL   = 19'd92;
  localparam logic [18:0] HF_RND   = 19'd50;
  localparam logic [19:0] RECIP_100 = 20'd671089;
  localparam int          RECIP_SH  = 26;

  localparam logic [ACT_W-1:0] ACT_PLAY     = 3'd0;
  localparam logic [ACT_W-1:0] ACT_TIMED    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_LOOP     = 3'd2;
  localparam logic [ACT_W-1:0] ACT_STOP     = 3'd3;
  localparam logic [ACT_W-1:0] ACT_VOLUME   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_MUFFLE   = 3'd5;
  localparam logic [ACT_W-1:0] ACT_TICK     = 3'd6;
  localparam logic [ACT_W-1:0] ACT_FINISHED = 3'd7;

  localparam logic [KIND_W-1:0] EV_START  = 2'd0;
  localparam logic [KIND_W-1:0] EV_STOP   = 2'd1;
  localparam logic [KIND_W-1:0] EV_GAIN   = 2'd2;
  localparam logic [KIND_W-1:0] EV_FILTER = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [VN_W-1:0]   id;
    logic [GAIN_W-1:0] gain;
    logic              fon;
    logic [GAIN_W-1:0] hf;
    logic              stolen;
    logic              last;
  } word_t;

  typedef struct packed {
    logic latch;
    logic rd_en;
    logic do_dec;
    logic do_start;
    logic tick_eval;
    logic mul_go;
    logic div_init;
    logic div_step;
    logic emit_fade;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             dur_zero;
    logic             active_at_idx;
    logic             fade_needed;
    logic             push_ok;
  } stat_t;

endpackage

FILE: src/vpa_in_if.sv
// ----------------------------------------------------------------------------
// Voice pool request channel
// Valid/ready channel carrying one request word.
// ----------------------------------------------------------------------------
interface vpa_in_if;
  logic                                valid;
  logic                                ready;
  logic [vpa_pkg::ACT_W-1:0]           action;
  logic [vpa_pkg::VN_W-1:0]            voice_number;
  logic [vpa_pkg::GAIN_W-1:0]          volume;
  logic [vpa_pkg::GAIN_W-1:0]          muffle;
  logic [vpa_pkg::TIME_W-1:0]          duration;
  logic [vpa_pkg::TIME_W-1:0]          fade_length;
  logic [vpa_pkg::TICK_W-1:0]          tick_amount;

  modport source (output valid, action, voice_number, volume, muffle, duration,
                  fade_length, tick_amount, input ready);
  modport sink (input valid, action, voice_number, volume, muffle, duration,
                fade_length, tick_amount, output ready);
endinterface

FILE: src/vpa_out_if.sv
// ----------------------------------------------------------------------------
// Voice pool event channel
// Valid/ready channel carrying one event word.
// ----------------------------------------------------------------------------
interface vpa_out_if;
  logic                        valid;
  logic                        ready;
  logic [vpa_pkg::KIND_W-1:0]  event_kind;
  logic [vpa_pkg::VN_W-1:0]    voice_id;
  logic [vpa_pkg::GAIN_W-1:0]  gain_value;
  logic                        filter_on;
  logic [vpa_pkg::GAIN_W-1:0]  filter_hf_gain;
  logic                        was_stolen;
  logic                        last_result;

  modport source (output valid, event_kind, voice_id, gain_value, filter_on,
                  filter_hf_gain, was_stolen, last_result, input ready);
  modport sink (input valid, event_kind, voice_id, gain_value, filter_on,
                filter_hf_gain, was_stolen, last_result, output ready);
endinterface

FILE: src/vpa_ctrl.sv
// ----------------------------------------------------------------------------
// Voice pool controller
// Sequences decode, allocation scan, tick scan and fade division.
// ----------------------------------------------------------------------------
module vpa_ctrl #(
  parameter int VOICE_COUNT = 32,
  parameter int IW = 5
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  vpa_pkg::stat_t  stat,
  output vpa_pkg::cmd_t   cmd,
  output logic [IW-1:0]   idx
);
  import vpa_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DEC    = 4'd1;
  localparam logic [3:0] S_PSCAN  = 4'd2;
  localparam logic [3:0] S_PDRAIN = 4'd3;
  localparam logic [3:0] S_PSEL   = 4'd4;
  localparam logic [3:0] S_TRD    = 4'd5;
  localparam logic [3:0] S_TEV    = 4'd6;
  localparam logic [3:0] S_TMUL   = 4'd7;
  localparam logic [3:0] S_TDINIT = 4'd8;
  localparam logic [3:0] S_TDIV   = 4'd9;
  localparam logic [3:0] S_TEMIT  = 4'd10;
  localparam logic [3:0] S_FIN    = 4'd11;

  localparam logic [IW-1:0] LAST = IW'(VOICE_COUNT - 1);

  logic [3:0]        state, state_next;
  logic [IW-1:0]     idx_next;
  logic [STEP_W-1:0] step, step_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    idx_next   = idx;
    step_next  = step;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (stat.push_ok) begin
          cmd.do_dec = 1'b1;
          idx_next   = '0;
          case (stat.action)
            ACT_PLAY, ACT_LOOP: state_next = S_PSCAN;
            ACT_TIMED: state_next = stat.dur_zero ? S_FIN : S_PSCAN;
            ACT_TICK: state_next = S_TRD;
            default: state_next = S_FIN;
          endcase
        end
      end
      S_PSCAN: begin
        cmd.rd_en = 1'b1;
        if (idx == LAST) state_next = S_PDRAIN;
        else idx_next = idx + 1'b1;
      end
      S_PDRAIN: state_next = S_PSEL;
      S_PSEL: begin
        if (stat.push_ok) begin
          cmd.do_start = 1'b1;
          state_next   = S_FIN;
        end
      end
      S_TRD: begin
        if (stat.active_at_idx) begin
          cmd.rd_en  = 1'b1;
          state_next = S_TEV;
        end else if (idx == LAST) begin
          state_next = S_FIN;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      S_TEV: begin
        if (stat.push_ok) begin
          cmd.tick_eval = 1'b1;
          if (stat.fade_needed) state_next = S_TMUL;
          else if (idx == LAST) state_next = S_FIN;
          else begin
            idx_next   = idx + 1'b1;
            state_next = S_TRD;
          end
        end
      end
      S_TMUL: begin
        cmd.mul_go = 1'b1;
        state_next = S_TDINIT;
      end
      S_TDINIT: begin
        cmd.div_init = 1'b1;
        step_next    = '0;
        state_next   = S_TDIV;
      end
      S_TDIV: begin
        cmd.div_step = 1'b1;
        if (step == STEP_W'(DIV_STEPS - 1)) state_next = S_TEMIT;
        else step_next = step + 1'b1;
      end
      S_TEMIT: begin
        if (stat.push_ok) begin
          cmd.emit_fade = 1'b1;
          if (idx == LAST) state_next = S_FIN;
          else begin
            idx_next   = idx + 1'b1;
            state_next = S_TRD;
          end
        end
      end
      S_FIN: begin
        if (stat.push_ok) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    idx  <= idx_next;
    step <= step_next;
  end

endmodule

FILE: src/vpa_dp.sv
// ----------------------------------------------------------------------------
// Voice pool datapath
// Voice flags, voice record memories, filter math, fade divider, event queue.
// ----------------------------------------------------------------------------
module vpa_dp #(
  parameter int VOICE_COUNT = 32,
  parameter int IW = 5
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         filt_avail,
  input  logic [vpa_pkg::ACT_W-1:0]    action,
  input  logic [vpa_pkg::VN_W-1:0]     voice_number,
  input  logic [vpa_pkg::GAIN_W-1:0]   volume,
  input  logic [vpa_pkg::GAIN_W-1:0]   muffle,
  input  logic [vpa_pkg::TIME_W-1:0]   duration,
  input  logic [vpa_pkg::TIME_W-1:0]   fade_length,
  input  logic [vpa_pkg::TICK_W-1:0]   tick_amount,
  input  vpa_pkg::cmd_t                cmd,
  input  logic [IW-1:0]                idx,
  output vpa_pkg::stat_t               stat,
  vpa_out_if.source                    rsp
);
  import vpa_pkg::*;

  logic [ACT_W-1:0]  act;
  logic [VN_W-1:0]   vn;
  logic [GAIN_W-1:0] vol, muf;
  logic [TIME_W-1:0] dur, fade;
  logic [TICK_W-1:0] tick;

  logic [VOICE_COUNT-1:0] active, timed, looping;

  logic [TIME_W-1:0] el_mem   [VOICE_COUNT];
  logic [TIME_W-1:0] len_mem  [VOICE_COUNT];
  logic [TIME_W-1:0] fade_mem [VOICE_COUNT];
  logic [GAIN_W-1:0] gain_mem [VOICE_COUNT];
  logic [TIME_W-1:0] rd_el, rd_len, rd_fade;
  logic [GAIN_W-1:0] rd_gain;

  logic              ev_valid;
  logic [IW-1:0]     ev_idx;
  logic              idle_found, best_found;
  logic [IW-1:0]     idle_idx, best_idx;
  logic [TIME_W-1:0] best_el;

  logic [TIME_W-1:0] rem_q;
  logic [PROD_W-1:0] prod;
  logic [TIME_W-1:0] div_r;
  logic [DIV_STEPS-1:0] div_low;
  logic [GAIN_W-1:0] quot;

  word_t             pend, out_q, word, pend_last;
  logic              pend_valid, out_valid, emit;
  logic              push, mark;
  logic [CNT_W-1:0]  res_cnt;

  logic [IW-1:0]     vi, sel;
  logic              in_range;

  logic [18:0]       fx;
  logic [38:0]       fprod;
  logic [GAIN_W-1:0] fmuf, cut, hfg, hf;
  logic              fon;

  logic [TIME_W:0]   esum;
  logic [TIME_W-1:0] e, rem;
  logic              expire;
  logic [TIME_W:0]   dtrial;
  logic              dge;

  logic              el_we, cfg_we_start;
  logic [IW-1:0]     el_wa;
  logic [TIME_W-1:0] el_wd;
  logic              gain_we;
  logic [IW-1:0]     gain_wa;

  assign vi       = vn[IW-1:0];
  assign in_range = 7'(vn) < 7'(VOICE_COUNT);
  assign sel      = idle_found ? idle_idx : (best_found ? best_idx : '0);

  // low-pass settings
  assign fmuf  = (act == ACT_LOOP) ? '0 : muf;
  assign fx    = 19'(fmuf) * HF_MUL + HF_RND;
  assign fprod = 39'(fx) * 39'(RECIP_100);
  assign cut   = fprod[RECIP_SH +: GAIN_W];
  always_comb begin
    hfg = (cut >= Q_ONE) ? '0 : Q_ONE - cut;
    if (hfg < HF_FLOOR) hfg = HF_FLOOR;
  end
  assign fon = (fmuf != '0) && filt_avail;
  assign hf  = fon ? hfg : Q_ONE;

  // tick arithmetic
  assign esum   = (TIME_W+1)'(rd_el) + (TIME_W+1)'(tick);
  assign e      = esum[TIME_W] ? TIME_MAX : esum[TIME_W-1:0];
  assign expire = e >= rd_len;
  assign rem    = rd_len - e;

  assign dtrial = {div_r, div_low[DIV_STEPS-1]};
  assign dge    = dtrial >= (TIME_W+1)'(rd_fade);

  always_comb begin
    word         = '0;
    word.hf      = Q_ONE;
    emit         = 1'b0;
    el_we        = 1'b0;
    el_wa        = idx;
    el_wd        = '0;
    gain_we      = 1'b0;
    gain_wa      = vi;
    cfg_we_start = 1'b0;
    if (cmd.do_dec && in_range) begin
      word.id = vn;
      case (act)
        ACT_STOP: begin
          if (looping[vi]) begin
            emit      = 1'b1;
            word.kind = EV_STOP;
          end
        end
        ACT_VOLUME: begin
          if (active[vi] && looping[vi]) begin
            emit      = 1'b1;
            gain_we   = 1'b1;
            word.kind = EV_GAIN;
            word.gain = vol;
          end
        end
        ACT_MUFFLE: begin
          if (active[vi] && looping[vi]) begin
            emit      = 1'b1;
            word.kind = EV_FILTER;
            word.fon  = fon;
            word.hf   = hf;
          end
        end
        default: ;
      endcase
    end
    if (cmd.do_start) begin
      emit         = 1'b1;
      cfg_we_start = 1'b1;
      el_we        = 1'b1;
      el_wa        = sel;
      gain_we      = 1'b1;
      gain_wa      = sel;
      word.kind    = EV_START;
      word.id      = VN_W'(sel);
      word.gain    = vol;
      word.fon     = fon;
      word.hf      = hf;
      word.stolen  = active[sel];
    end
    if (cmd.tick_eval) begin
      el_we = 1'b1;
      el_wd = e;
      if (timed[idx] && expire) begin
        emit      = 1'b1;
        word.kind = EV_STOP;
        word.id   = VN_W'(idx);
      end
    end
    if (cmd.emit_fade) begin
      emit      = 1'b1;
      word.kind = EV_GAIN;
      word.id   = VN_W'(idx);
      word.gain = quot;
    end
  end

  assign stat.action        = act;
  assign stat.dur_zero      = (dur == '0);
  assign stat.active_at_idx = active[idx];
  assign stat.fade_needed   = timed[idx] && !expire && (rd_fade != '0) && (rem < rd_fade);
  assign stat.push_ok       = !pend_valid || !out_valid || rsp.ready;

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act  <= action;
      vn   <= voice_number;
      vol  <= (volume > Q_ONE) ? Q_ONE : volume;
      muf  <= (muffle > Q_ONE) ? Q_ONE : muffle;
      dur  <= duration;
      fade <= fade_length;
      tick <= tick_amount;
    end
  end

  // voice flags
  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= '0;
      timed   <= '0;
      looping <= '0;
    end else begin
      if (cmd.do_dec && in_range) begin
        case (act)
          ACT_STOP: begin
            if (looping[vi]) begin
              active[vi]  <= 1'b0;
              looping[vi] <= 1'b0;
            end
          end
          ACT_FINISHED: begin
            if (active[vi] && !timed[vi] && !looping[vi]) active[vi] <= 1'b0;
          end
          default: ;
        endcase
      end
      if (cmd.do_start) begin
        active[sel]  <= 1'b1;
        timed[sel]   <= (act == ACT_TIMED);
        looping[sel] <= (act == ACT_LOOP);
      end
      if (cmd.tick_eval && timed[idx] && expire) active[idx] <= 1'b0;
    end
  end

  // voice record memories
  always_ff @(posedge clk) begin
    if (el_we) el_mem[el_wa] <= el_wd;
    if (gain_we) gain_mem[gain_wa] <= vol;
    if (cfg_we_start && act == ACT_TIMED) begin
      len_mem[sel]  <= dur;
      fade_mem[sel] <= fade;
    end
    if (cmd.rd_en) begin
      rd_el   <= el_mem[idx];
      rd_len  <= len_mem[idx];
      rd_fade <= fade_mem[idx];
      rd_gain <= gain_mem[idx];
    end
  end

  // allocation scan
  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else begin
      ev_valid <= cmd.rd_en;
    end
    ev_idx <= idx;
    if (cmd.latch) begin
      idle_found <= 1'b0;
      best_found <= 1'b0;
    end else if (ev_valid) begin
      if (!active[ev_idx] && !idle_found) begin
        idle_found <= 1'b1;
        idle_idx   <= ev_idx;
      end
      if (!looping[ev_idx] && (!best_found || rd_el > best_el)) begin
        best_found <= 1'b1;
        best_idx   <= ev_idx;
        best_el    <= rd_el;
      end
    end
  end

  // fade divider
  always_ff @(posedge clk) begin
    if (cmd.tick_eval) rem_q <= rem;
    if (cmd.mul_go) prod <= PROD_W'(rd_gain) * PROD_W'(rem_q);
    if (cmd.div_init) begin
      div_r   <= prod[PROD_W-1 -: TIME_W];
      div_low <= prod[DIV_STEPS-1:0];
    end else if (cmd.div_step) begin
      div_r   <= dge ? TIME_W'(dtrial - (TIME_W+1)'(rd_fade)) : dtrial[TIME_W-1:0];
      div_low <= {div_low[DIV_STEPS-2:0], 1'b0};
      quot    <= {quot[GAIN_W-2:0], dge};
    end
  end

  // event queue: hold one word back to mark the last
  assign push = emit && (res_cnt != CNT_W'(MAX_RESULTS));
  assign mark = cmd.flush && pend_valid;

  always_comb begin
    pend_last      = pend;
    pend_last.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      res_cnt    <= '0;
    end else begin
      if ((push && pend_valid) || mark) out_valid <= 1'b1;
      else if (out_valid && rsp.ready) out_valid <= 1'b0;
      if (push) pend_valid <= 1'b1;
      else if (mark) pend_valid <= 1'b0;
      if (cmd.latch) res_cnt <= '0;
      else if (push) res_cnt <= res_cnt + 1'b1;
    end
    if (push) pend <= word;
    if (push && pend_valid) out_q <= pend;
    else if (mark) out_q <= pend_last;
  end

  assign rsp.valid          = out_valid;
  assign rsp.event_kind     = out_q.kind;
  assign rsp.voice_id       = out_q.id;
  assign rsp.gain_value     = out_q.gain;
  assign rsp.filter_on      = out_q.fon;
  assign rsp.filter_hf_gain = out_q.hf;
  assign rsp.was_stolen     = out_q.stolen;
  assign rsp.last_result    = out_q.last;

endmodule

FILE: src/voice_pool_allocator_with_fade_top.sv
// Play request: runs the per-voice allocation scan over the voice record memory.
// Tick: visits every voice and reads each active one; a fading voice also
// runs the multiply and 13-step divider. Other commands only decode and flush.
// One request at a time; a waiting word stalls it.
// Reset (rst, synchronous): voices idle, filter_available set; the record
// memories are not cleared, as an entry only counts after a start writes it.
// ----------------------------------------------------------------------------
// Voice pool allocator with fade
// Top level: configuration register, controller and datapath.
// ----------------------------------------------------------------------------
`include "voice_pool_allocator_with_fade_top_assert.svh"

module voice_pool_allocator_with_fade_top #(
  parameter int VOICE_COUNT = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic      cfg_data,
  vpa_in_if.sink    req,
  vpa_out_if.source rsp
);
  import vpa_pkg::*;

  localparam int IW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

  logic          filt_avail;
  cmd_t          cmd;
  stat_t         stat;
  logic [IW-1:0] idx;
  logic          no_gain_ev;

  assign no_gain_ev = rsp.valid &&
                      (rsp.event_kind == EV_STOP || rsp.event_kind == EV_FILTER);

  always_ff @(posedge clk) begin
    if (rst) begin
      filt_avail <= 1'b1;
    end else if (cfg_we) begin
      filt_avail <= cfg_data;
    end
  end

  vpa_ctrl #(.VOICE_COUNT(VOICE_COUNT), .IW(IW)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd),
    .idx      (idx)
  );

  vpa_dp #(.VOICE_COUNT(VOICE_COUNT), .IW(IW)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .filt_avail   (filt_avail),
    .action       (req.action),
    .voice_number (req.voice_number),
    .volume       (req.volume),
    .muffle       (req.muffle),
    .duration     (req.duration),
    .fade_length  (req.fade_length),
    .tick_amount  (req.tick_amount),
    .cmd          (cmd),
    .idx          (idx),
    .stat         (stat),
    .rsp          (rsp)
  );

  `VPA_ASSERT_NXT(a_one_at_a_time, req.valid && req.ready, !req.ready)
  `VPA_ASSERT_IMP(a_no_filter, rsp.valid && !filt_avail, !rsp.filter_on)
  `VPA_ASSERT_IMP(a_zero_gain, no_gain_ev, rsp.gain_value == '0)
  `VPA_ASSERT_IMP(a_stolen_start, rsp.valid && rsp.was_stolen, rsp.event_kind == EV_START)

endmodule

FILE: tb/sv/tb_voice_pool_allocator_with_fade_top.sv
// ----------------------------------------------------------------------------
// Voice pool allocator testbench
// Drives request words through a queue-fed driver and checks every event word
// against an in-bench voice pool predictor. The run covers directed corners,
// random traffic under several idle/stall mixes, filter on/off settings, a
// long output hold-off, and pool-filling runs that reach stealing.
// ----------------------------------------------------------------------------
module tb_voice_pool_allocator_with_fade_top;
  import vpa_pkg::*;

  localparam int NV = 32;
  localparam int SETTLE = 700;
  localparam int LIMIT = 3000000;

  typedef struct {
    logic [ACT_W-1:0]  action;
    logic [VN_W-1:0]   vn;
    logic [GAIN_W-1:0] vol;
    logic [GAIN_W-1:0] muf;
    logic [TIME_W-1:0] dur;
    logic [TIME_W-1:0] fade;
    logic [TICK_W-1:0] tick;
  } req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_data = 1'b0;

  vpa_in_if  req();
  vpa_out_if rsp();

  voice_pool_allocator_with_fade_top #(.VOICE_COUNT(NV)) u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data), .req(req), .rsp(rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  req_t  send_q[$];
  word_t event_q[$];
  req_t  cur_req;
  logic  in_fire = 1'b0;
  int    idle_in = 0;
  int    stall_out = 0;
  int    errors = 0;
  int    cycles = 0;
  logic  hold_go = 1'b0;
  logic  hold_done = 1'b0;
  int    hold_cnt = 0;

  bit          pool_filter;
  bit          pool_act[NV];
  bit          pool_tmd[NV];
  bit          pool_loop[NV];
  int unsigned pool_el[NV];
  int unsigned pool_len[NV];
  int unsigned pool_fade[NV];
  int unsigned pool_gain[NV];
  int unsigned pool_muf[NV];

  function automatic void pool_clear();
    pool_filter = 1'b1;
    for (int i = 0; i < NV; i++) begin
      pool_act[i] = 0; pool_tmd[i] = 0; pool_loop[i] = 0; pool_el[i] = 0;
      pool_len[i] = 0; pool_fade[i] = 0; pool_gain[i] = 4096; pool_muf[i] = 0;
    end
  endfunction

  function automatic int unsigned q_clamp(longint unsigned v);
    return (v > 4096) ? 4096 : int'(v);
  endfunction

  function automatic word_t mk_event(logic [KIND_W-1:0] k, int id, int unsigned g,
                                     int unsigned m, bit use_filter, bit st);
    word_t w;
    int unsigned cut, hf;
    cut = (m * 92 + 50) / 100;
    hf = (cut >= 4096) ? 0 : 4096 - cut;
    if (hf < 123) hf = 123;
    w.kind = k;
    w.id = id[VN_W-1:0];
    w.gain = g[GAIN_W-1:0];
    w.fon = 1'b0;
    w.hf = Q_ONE;
    if (use_filter && m != 0 && pool_filter) begin
      w.fon = 1'b1;
      w.hf = hf[GAIN_W-1:0];
    end
    w.stolen = st;
    w.last = 1'b0;
    return w;
  endfunction

  function automatic void pool_step(req_t r);
    word_t evs[$];
    int unsigned vol, muf, e, rem;
    int v, best;
    bit in_rng;
    vol = q_clamp(r.vol);
    muf = q_clamp(r.muf);
    in_rng = r.vn < NV;
    if (r.action == ACT_PLAY || r.action == ACT_TIMED || r.action == ACT_LOOP) begin
      if (!(r.action == ACT_TIMED && r.dur == 0)) begin
        if (r.action == ACT_LOOP) muf = 0;
        v = -1;
        for (int i = 0; i < NV; i++)
          if (v < 0 && !pool_act[i]) v = i;
        if (v < 0) begin
          best = -1;
          for (int i = 0; i < NV; i++)
            if (!pool_loop[i] && (best < 0 || pool_el[i] > pool_el[best])) best = i;
          v = (best < 0) ? 0 : best;
        end
        evs = {evs, mk_event(EV_START, v, vol, muf, 1'b1, pool_act[v])};
        pool_act[v] = 1;
        pool_tmd[v] = (r.action == ACT_TIMED);
        pool_loop[v] = (r.action == ACT_LOOP);
        pool_el[v] = 0;
        if (r.action == ACT_TIMED) begin
          pool_len[v] = r.dur;
          pool_fade[v] = r.fade;
        end
        pool_gain[v] = vol;
        pool_muf[v] = muf;
      end
    end else if (r.action == ACT_STOP) begin
      if (in_rng && pool_loop[r.vn]) begin
        pool_act[r.vn] = 0;
        pool_loop[r.vn] = 0;
        evs = {evs, mk_event(EV_STOP, r.vn, 0, 0, 1'b0, 1'b0)};
      end
    end else if (r.action == ACT_VOLUME) begin
      if (in_rng && pool_act[r.vn] && pool_loop[r.vn]) begin
        pool_gain[r.vn] = vol;
        evs = {evs, mk_event(EV_GAIN, r.vn, vol, 0, 1'b0, 1'b0)};
      end
    end else if (r.action == ACT_MUFFLE) begin
      if (in_rng && pool_act[r.vn] && pool_loop[r.vn]) begin
        pool_muf[r.vn] = muf;
        evs = {evs, mk_event(EV_FILTER, r.vn, 0, muf, 1'b1, 1'b0)};
      end
    end else if (r.action == ACT_TICK) begin
      for (int i = 0; i < NV; i++) begin
        if (pool_act[i]) begin
          e = pool_el[i] + r.tick;
          if (e > 24'hFFFFFF) e = 24'hFFFFFF;
          pool_el[i] = e;
          if (pool_tmd[i]) begin
            if (e >= pool_len[i]) begin
              pool_act[i] = 0;
              evs = {evs, mk_event(EV_STOP, i, 0, 0, 1'b0, 1'b0)};
            end else if (pool_fade[i] > 0) begin
              rem = pool_len[i] - e;
              if (rem < pool_fade[i])
                evs = {evs, mk_event(EV_GAIN, i, q_clamp(
                  (longint'(pool_gain[i]) * rem) / pool_fade[i]), 0, 1'b0, 1'b0)};
            end
          end
        end
      end
    end else begin
      if (in_rng && pool_act[r.vn] && !pool_tmd[r.vn] && !pool_loop[r.vn])
        pool_act[r.vn] = 0;
    end
    if (evs.size() > 0) evs[evs.size()-1].last = 1'b1;
    event_q = {event_q, evs};
  endfunction

  function automatic req_t mk_req(logic [ACT_W-1:0] a, int vn, int vol, int muf,
                                  int dur, int fade, int tick);
    req_t r;
    r.action = a; r.vn = vn; r.vol = vol; r.muf = muf;
    r.dur = dur; r.fade = fade; r.tick = tick;
    return r;
  endfunction

  function automatic req_t rand_req();
    req_t r;
    int p;
    p = $urandom_range(99);
    if (p < 20) r.action = ACT_PLAY;
    else if (p < 35) r.action = ACT_TIMED;
    else if (p < 46) r.action = ACT_LOOP;
    else if (p < 53) r.action = ACT_STOP;
    else if (p < 60) r.action = ACT_VOLUME;
    else if (p < 67) r.action = ACT_MUFFLE;
    else if (p < 88) r.action = ACT_TICK;
    else r.action = ACT_FINISHED;
    r.vn = ($urandom_range(99) < 90) ? $urandom_range(NV-1) : $urandom_range(63, NV);
    r.vol = ($urandom_range(99) < 80) ? $urandom_range(4096) : $urandom_range(8191);
    p = $urandom_range(99);
    r.muf = (p < 15) ? 0 : (p < 80) ? $urandom_range(4096) : $urandom_range(8191);
    p = $urandom_range(99);
    r.dur = (p < 5) ? 0 : (p < 10) ? $urandom_range(24'hFFFFFF) : $urandom_range(3000, 1);
    p = $urandom_range(99);
    r.fade = (p < 20) ? 0 : (p < 25) ? $urandom_range(24'hFFFFFF) : $urandom_range(r.dur);
    p = $urandom_range(99);
    r.tick = (p < 5) ? 16'hFFFF : (p < 10) ? $urandom_range(16'hFFFF) : $urandom_range(400);
    return r;
  endfunction

  always @(posedge clk) begin
    word_t got, want;
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("status: fail");
      $finish;
    end
    if (rst) begin
      pool_clear();
      in_fire <= 1'b0;
    end else begin
      in_fire <= req.valid && req.ready;
      if (cfg_we) pool_filter = cfg_data;
      if (req.valid && req.ready) pool_step(cur_req);
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.event_kind, rsp.voice_id, rsp.gain_value, rsp.filter_on,
                rsp.filter_hf_gain, rsp.was_stolen, rsp.last_result};
        if (event_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected event word %p", got);
        end else begin
          want = event_q.pop_front();
          if (got.kind !== want.kind || got.id !== want.id || got.gain !== want.gain ||
              got.fon !== want.fon || got.hf !== want.hf || got.stolen !== want.stolen ||
              got.last !== want.last) begin
            errors++;
            if (errors <= 10) $display("event mismatch: expected %p got %p", want, got);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_go && !hold_done && hold_cnt == 0) begin
      hold_cnt <= 3000;
      hold_done <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  always @(negedge clk) begin
    req_t it;
    if (rst) begin
      req.valid <= 1'b0;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= (hold_cnt == 0) && ($urandom_range(99) >= stall_out);
      if (!req.valid || in_fire) begin
        if (send_q.size() > 0 && $urandom_range(99) >= idle_in) begin
          it = send_q.pop_front();
          cur_req <= it;
          req.valid <= 1'b1;
          req.action <= it.action;
          req.voice_number <= it.vn;
          req.volume <= it.vol;
          req.muffle <= it.muf;
          req.duration <= it.dur;
          req.fade_length <= it.fade;
          req.tick_amount <= it.tick;
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  task automatic drain();
    while (send_q.size() > 0 || req.valid || event_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_filter(bit v);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_data = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic add_random(int n);
    repeat (n) send_q = {send_q, rand_req()};
  endtask

  task automatic fill_and_age();
    for (int i = 0; i < NV; i++)
      send_q = {send_q, mk_req(ACT_PLAY, 0, $urandom_range(4096), $urandom_range(4096),
                               0, 0, 0)};
    repeat (3) send_q = {send_q, mk_req(ACT_TICK, 0, 0, 0, 0, 0, 16'hFFFF)};
    repeat (2) send_q = {send_q, mk_req(ACT_PLAY, 0, 4096, 700, 0, 0, 0)};
    send_q = {send_q, mk_req(ACT_TICK, 0, 0, 0, 0, 0, 5)};
    repeat (NV + 1)
      send_q = {send_q, mk_req(ACT_LOOP, 0, $urandom_range(4096), 99, 0, 0, 0)};
    for (int i = 0; i < NV; i++) send_q = {send_q, mk_req(ACT_STOP, i, 0, 0, 0, 0, 0)};
  endtask

  initial begin
    req.valid = 1'b0;
    req.action = ACT_PLAY;
    req.voice_number = '0;
    req.volume = '0;
    req.muffle = '0;
    req.duration = '0;
    req.fade_length = '0;
    req.tick_amount = '0;
    rsp.ready = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_q = {send_q, mk_req(ACT_PLAY, 0, 0, 0, 0, 0, 0)};
    send_q = {send_q, mk_req(ACT_PLAY, 0, 8191, 8191, 0, 0, 0)};
    send_q = {send_q, mk_req(ACT_PLAY, 0, 4096, 1, 0, 0, 0)};
    send_q = {send_q, mk_req(ACT_PLAY, 0, 2048, 4096, 0, 0, 0)};
    send_q = {send_q, mk_req(ACT_TIMED, 0, 3000, 500, 0, 10, 0)};
    send_q = {send_q, mk_req(ACT_TIMED, 0, 4096, 0, 100, 50, 0)};
    send_q = {send_q, mk_req(ACT_TIMED, 0, 4095, 300, 24'hFFFFFF, 24'hFFFFFF, 0)};
    send_q = {send_q, mk_req(ACT_LOOP, 0, 1000, 123, 0, 0, 0)};
    send_q = {send_q, mk_req(ACT_STOP, 6, 0, 0, 0, 0, 0)};
    send_q = {send_q, mk_req(ACT_VOLUME, 6, 100, 0, 0, 0, 0)};
    send_q = {send_q, mk_req(ACT_LOOP, 0, 8191, 0, 0, 0, 0)};
    send_q = {send_q, mk_req(ACT_VOLUME, 6, 5000, 0, 0, 0, 0)};
    send_q = {send_q, mk_req(ACT_MUFFLE, 6, 0, 2000, 0, 0, 0)};
    send_q = {send_q, mk_req(ACT_MUFFLE, 6, 0, 0, 0, 0, 0)};
    send_q = {send_q, mk_req(ACT_STOP, 40, 0, 0, 0, 0, 0)};
    send_q = {send_q, mk_req(ACT_FINISHED, 0, 0, 0, 0, 0, 0)};
    send_q = {send_q, mk_req(ACT_FINISHED, 4, 0, 0, 0, 0, 0)};
    send_q = {send_q, mk_req(ACT_FINISHED, 63, 0, 0, 0, 0, 0)};
    send_q = {send_q, mk_req(ACT_TICK, 0, 0, 0, 0, 0, 60)};
    send_q = {send_q, mk_req(ACT_TICK, 0, 0, 0, 0, 0, 0)};
    send_q = {send_q, mk_req(ACT_TICK, 0, 0, 0, 0, 0, 16'hFFFF)};
    send_q = {send_q, mk_req(ACT_PLAY, 0, 4096, 4450, 0, 0, 0)};
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      set_filter(ph[0]);
      idle_in = (ph == 1 || ph == 3) ? ((ph == 1) ? 85 : 21) : 0;
      stall_out = (ph == 2 || ph == 3) ? ((ph == 2) ? 85 : 21) : 0;
      add_random(30);
      drain();
      idle_in = 0;
      stall_out = 0;
      add_random(15);
      drain();
    end

    set_filter(1'b1);
    hold_go = 1'b1;
    add_random(10);
    drain();
    add_random(5);
    drain();

    stall_out = 21;
    fill_and_age();
    drain();

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
